>>> sv/assert_macros.svh
// Assertion macros shared by pkc_core and power_key_press_classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define PKC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, disabled while reset is held.
`define PKC_ASSERT_IMP(label, ante, cons, msg) \
  `PKC_ASSERT(label, (ante) |-> (cons), msg)

// Clocked next-cycle implication, disabled while reset is held.
`define PKC_ASSERT_NXT(label, ante, cons, msg) \
  `PKC_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> sv/pkc_pkg.sv
// Types and constants for the power key press classifier.
package pkc_pkg;

  localparam int unsigned CFG_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] SHUTDOWN_RST = 16'd3000;
  localparam logic [CFG_W-1:0] SHORT_RST    = 16'd1000;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_SHUTDOWN = 2'd1,
    REG_SHORT    = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PROMPT   = 2'd1,
    EV_SHUTDOWN = 2'd2,
    EV_SHORT    = 2'd3
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] shutdown_ms;
    logic [CFG_W-1:0] short_press_ms;
  } cfg_t;

  typedef struct packed {
    event_t event_res;
    logic   power_enable;
  } step_res_t;

endpackage

>>> sv/pkc_cfg.sv
// APB register file holding the three timing thresholds.
module pkc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pkc_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [pkc_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [pkc_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready,
  output pkc_pkg::cfg_t                     cfg
);
  import pkc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[APB_ADDR_W-1:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_DEBOUNCE: cfg_nxt.debounce_ms    = cfg_pwdata[CFG_W-1:0];
        REG_SHUTDOWN: cfg_nxt.shutdown_ms    = cfg_pwdata[CFG_W-1:0];
        REG_SHORT:    cfg_nxt.short_press_ms = cfg_pwdata[CFG_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEBOUNCE: cfg_prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_r.debounce_ms};
      REG_SHUTDOWN: cfg_prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_r.shutdown_ms};
      REG_SHORT:    cfg_prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_r.short_press_ms};
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms    <= DEBOUNCE_RST;
      cfg_r.shutdown_ms    <= SHUTDOWN_RST;
      cfg_r.short_press_ms <= SHORT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/pkc_core.sv
// Debounce, hold timing and event classification state for one key poll.
module pkc_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           commit,
  input  logic                           key_level,
  input  logic [pkc_pkg::TIME_W-1:0]     now_ms,
  input  pkc_pkg::cfg_t                  cfg,
  output pkc_pkg::step_res_t             res
);
  import pkc_pkg::*;
  `include "assert_macros.svh"

  logic              prev_raw_r,       prev_raw_nxt;
  logic              stable_level_r,   stable_level_nxt;
  logic [TIME_W-1:0] change_time_r,    change_time_nxt;
  logic [TIME_W-1:0] press_start_r,    press_start_nxt;
  logic              held_r,           held_nxt;
  logic              prompt_pending_r, prompt_pending_nxt;
  logic              power_latch_r,    power_latch_nxt;

  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] hold;
  logic              hold_ge_shut;
  logic              hold_lt_short;
  event_t            ev;

  always_comb begin
    prev_raw_nxt       = key_level;
    change_time_nxt    = (key_level != prev_raw_r) ? now_ms : change_time_r;
    // elapsed is zero on a change poll, so the new level waits at least one poll
    elapsed            = now_ms - change_time_nxt;
    stable_level_nxt   = (elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms}) ?
                         key_level : stable_level_r;
    hold               = now_ms - press_start_r;
    hold_ge_shut       = hold >= {{(TIME_W-CFG_W){1'b0}}, cfg.shutdown_ms};
    hold_lt_short      = hold <  {{(TIME_W-CFG_W){1'b0}}, cfg.short_press_ms};

    press_start_nxt    = press_start_r;
    held_nxt           = held_r;
    prompt_pending_nxt = prompt_pending_r;
    power_latch_nxt    = power_latch_r;
    ev                 = EV_NONE;

    if (!stable_level_nxt) begin
      if (!held_r) begin
        held_nxt           = 1'b1;
        press_start_nxt    = now_ms;
        prompt_pending_nxt = 1'b0;
      end else if (!prompt_pending_r && hold_ge_shut) begin
        prompt_pending_nxt = 1'b1;
        ev                 = EV_PROMPT;
      end
    end else if (held_r) begin
      held_nxt = 1'b0;
      if (prompt_pending_r) begin
        prompt_pending_nxt = 1'b0;
        power_latch_nxt    = 1'b0;
        ev                 = EV_SHUTDOWN;
      end else if (!hold_ge_shut && hold_lt_short) begin
        ev = EV_SHORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r       <= 1'b1;
      stable_level_r   <= 1'b1;
      change_time_r    <= '0;
      press_start_r    <= '0;
      held_r           <= 1'b0;
      prompt_pending_r <= 1'b0;
      power_latch_r    <= 1'b1;
    end else if (commit) begin
      prev_raw_r       <= prev_raw_nxt;
      stable_level_r   <= stable_level_nxt;
      change_time_r    <= change_time_nxt;
      press_start_r    <= press_start_nxt;
      held_r           <= held_nxt;
      prompt_pending_r <= prompt_pending_nxt;
      power_latch_r    <= power_latch_nxt;
    end
  end

  assign res.event_res    = ev;
  assign res.power_enable = power_latch_nxt;

  `PKC_ASSERT_NXT(a_latch_sticky, !power_latch_r, !power_latch_r,
                  "power latch came back on without reset")
  `PKC_ASSERT_IMP(a_prompt_needs_hold, prompt_pending_r, held_r,
                  "prompt pending while no press is held")
  `PKC_ASSERT_NXT(a_shutdown_drops, commit && res.event_res == EV_SHUTDOWN, !power_latch_r,
                  "shutdown event did not clear power latch")

endmodule

>>> sv/power_key_press_classifier.sv
// Power key press classifier: input register, classifier step, result register.
// Polls move from the input register to the result register, one per cycle while
// no valid result is stalled; the input register refills in the cycle it drains.
// A stalled result blocks at most the one poll waiting in the input register.
// Synchronous active-low reset: thresholds 50/3000/1000 ms, key released, power on.
module power_key_press_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_key_level,
  input  logic [pkc_pkg::TIME_W-1:0]        in_now_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_event_res,
  output logic                              out_power_enable,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pkc_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [pkc_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [pkc_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import pkc_pkg::*;
  `include "assert_macros.svh"

  cfg_t              cfg;
  step_res_t         res;

  logic              in_vld_r;
  logic              key_r;
  logic [TIME_W-1:0] now_r;
  logic              out_vld_r;
  event_t            event_r;
  logic              power_r;
  logic              adv;
  logic              in_take;

  pkc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pkc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (adv),
    .key_level (key_r),
    .now_ms    (now_r),
    .cfg       (cfg),
    .res       (res)
  );

  // held poll moves to the result register when that register is free or draining
  assign adv      = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~adv;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_take | (in_vld_r & ~adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      key_r <= in_key_level;
      now_r <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      event_r   <= EV_NONE;
      power_r   <= 1'b1;
    end else begin
      if (adv) begin
        out_vld_r <= 1'b1;
        event_r   <= res.event_res;
        power_r   <= res.power_enable;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_event_res    = event_r;
  assign out_power_enable = power_r;

  `PKC_ASSERT_NXT(a_adv_fills_out, adv, out_vld_r,
                  "transfer into result register lost")
  `PKC_ASSERT_NXT(a_in_held, in_vld_r && !adv, in_vld_r,
                  "waiting poll dropped from input register")
  `PKC_ASSERT_IMP(a_power_fall_event, $fell(power_r), event_r == EV_SHUTDOWN,
                  "power dropped without a shutdown event")

endmodule

>>> sim/tb_top.sv
// Testbench for the power key press classifier: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

module tb_top;
  import pkc_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned LIMIT_CYCLES = 400000;

  class press_scoreboard;
    logic [CFG_W-1:0]  debounce_ms;
    logic [CFG_W-1:0]  shutdown_ms;
    logic [CFG_W-1:0]  short_ms;
    logic              last_raw;
    logic              stable_lvl;
    logic              held;
    logic              prompt_pending;
    logic              power_on;
    logic [TIME_W-1:0] change_t;
    logic [TIME_W-1:0] press_t;
    step_res_t         expected_q[$];
    int unsigned       n_polls;
    int unsigned       n_checked;
    int unsigned       n_errors;
    int unsigned       event_tally[4];

    function new();
      debounce_ms    = DEBOUNCE_RST;
      shutdown_ms    = SHUTDOWN_RST;
      short_ms       = SHORT_RST;
      last_raw       = 1'b1;
      stable_lvl     = 1'b1;
      held           = 1'b0;
      prompt_pending = 1'b0;
      power_on       = 1'b1;
      change_t       = '0;
      press_t        = '0;
      n_polls        = 0;
      n_checked      = 0;
      n_errors       = 0;
      foreach (event_tally[i]) event_tally[i] = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_DEBOUNCE: debounce_ms = val;
        REG_SHUTDOWN: shutdown_ms = val;
        REG_SHORT:    short_ms = val;
        default: ;
      endcase
    endfunction

    // One poll in, one expected result queued.
    function void note_poll(logic key, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] since_change;
      logic [TIME_W-1:0] hold;
      event_t            ev;
      ev = EV_NONE;
      if (key != last_raw) change_t = now;
      since_change = now - change_t;
      if (since_change > {16'h0, debounce_ms}) stable_lvl = key;
      last_raw = key;
      hold = now - press_t;
      if (!stable_lvl) begin
        if (!held) begin
          // first debounced press only starts the hold timer
          held           = 1'b1;
          press_t        = now;
          prompt_pending = 1'b0;
        end else if (!prompt_pending && hold >= {16'h0, shutdown_ms}) begin
          prompt_pending = 1'b1;
          ev             = EV_PROMPT;
        end
      end else if (held) begin
        if (prompt_pending) begin
          prompt_pending = 1'b0;
          power_on       = 1'b0;
          ev             = EV_SHUTDOWN;
        end else if (hold < {16'h0, shutdown_ms} && hold < {16'h0, short_ms}) begin
          ev = EV_SHORT;
        end
        held = 1'b0;
      end
      n_polls++;
      event_tally[ev]++;
      expected_q.push_back('{event_res: ev, power_enable: power_on});
    endfunction

    task report_mismatch(string what);
      n_errors++;
      $display("tb_top: mismatch %0d: %s", n_errors, what);
    endtask

    task check_result(logic [1:0] ev, logic pe);
      step_res_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result event=%0d power=%0b with no poll pending", ev, pe));
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (ev !== want.event_res)
        report_mismatch($sformatf("result %0d: event %0d, expected %s",
                                  n_checked, ev, want.event_res.name()));
      if (pe !== want.power_enable)
        report_mismatch($sformatf("result %0d: power_enable %0b, expected %0b",
                                  n_checked, pe, want.power_enable));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_key_level = 1'b1;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_event_res;
  logic                  out_power_enable;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  press_scoreboard   sb = new();
  logic [TIME_W-1:0] poll_ms = '0;
  bit                quiet_tail = 1'b0;
  bit                send_gaps = 1'b1;
  int unsigned       n_settings = 0;

  power_key_press_classifier i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_level     (in_key_level),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_power_enable (out_power_enable),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("tb_top: FAIL");
    $finish;
  end

  // Result side: check every transfer, stall in random bursts.
  initial begin : result_sink
    int unsigned burst = 0;
    bit          stall_mode = 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_event_res, out_power_enable);
      if ($urandom_range(0, 63) == 0) stall_mode = !stall_mode;
      if (burst == 0 && stall_mode && !quiet_tail && $urandom_range(0, 5) == 0)
        burst = $urandom_range(1, 8);
      if (burst != 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic feed(logic key, logic [TIME_W-1:0] now);
    in_valid     <= 1'b1;
    in_key_level <= key;
    in_now_ms    <= now;
    do @(posedge clk); while (in_stall);
    sb.note_poll(key, now);
    if (!quiet_tail && send_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    // result register may still be settling
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'h0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, val);
  endtask

  task automatic write_cfg(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] sd, logic [CFG_W-1:0] sp);
    apb_write(REG_DEBOUNCE, deb);
    apb_write(REG_SHUTDOWN, sd);
    apb_write(REG_SHORT, sp);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    n_settings++;
  endtask

  function automatic int unsigned time_span();
    int unsigned span;
    span = 8;
    if (sb.shutdown_ms > span) span = 32'(sb.shutdown_ms);
    if (sb.short_ms > span) span = 32'(sb.short_ms);
    return span;
  endfunction

  // Bounce, debounced press, hold of random length, release.
  task automatic run_press();
    int unsigned deb;
    int unsigned span;
    int unsigned n;
    deb  = 32'(sb.debounce_ms);
    span = time_span();
    repeat ($urandom_range(0, 3)) begin
      poll_ms += $urandom_range(0, deb);
      feed(1'($urandom_range(0, 1)), poll_ms);
    end
    poll_ms += $urandom_range(0, deb);
    feed(1'b0, poll_ms);
    // exactly the debounce time does not qualify, one more does
    poll_ms += deb + $urandom_range(0, 1);
    feed(1'b0, poll_ms);
    n = $urandom_range(1, 6);
    repeat (n) begin
      poll_ms += $urandom_range(0, (2 * span) / n + 1);
      feed(1'b0, poll_ms);
    end
    poll_ms += $urandom_range(0, 3);
    feed(1'b1, poll_ms);
    poll_ms += deb + $urandom_range(0, 2);
    feed(1'b1, poll_ms);
    if ($urandom_range(0, 1)) begin
      poll_ms += $urandom_range(0, span);
      feed(1'b1, poll_ms);
    end
  endtask

  // Random levels with jumps, including backwards and across the wrap.
  task automatic run_noise();
    int unsigned span;
    span = time_span();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 2))
        0:       poll_ms = $urandom;
        1:       poll_ms -= $urandom_range(0, 2 * span);
        default: poll_ms += $urandom_range(0, 4 * span);
      endcase
      feed(1'($urandom_range(0, 1)), poll_ms);
    end
  endtask

  task automatic run_phase(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] sd,
                           logic [CFG_W-1:0] sp, int unsigned n_items);
    int unsigned target;
    drain_results();
    write_cfg(deb, sd, sp);
    poll_ms = $urandom;
    target  = sb.n_polls + n_items;
    while (sb.n_polls < target) begin
      send_gaps = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 7) == 0) run_noise();
      else run_press();
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: 50 / 3000 / 1000
    feed(1'b1, 32'd0);
    feed(1'b1, 32'hFFFF_FFFF);
    feed(1'b0, 32'd100);
    feed(1'b0, 32'd151);
    feed(1'b0, 32'd200);
    feed(1'b1, 32'd300);
    feed(1'b1, 32'd351);
    // stable for exactly the debounce time, then hold up to the prompt
    feed(1'b0, 32'd400);
    feed(1'b0, 32'd450);
    feed(1'b0, 32'd451);
    feed(1'b0, 32'd3450);
    feed(1'b0, 32'd3451);
    feed(1'b1, 32'd5000);
    feed(1'b1, 32'd5051);
    // long hold released with no prompt seen
    feed(1'b0, 32'd6000);
    feed(1'b0, 32'd6051);
    feed(1'b1, 32'd6061);
    feed(1'b1, 32'd10061);
    // timestamps running backwards
    feed(1'b0, 32'd20000);
    feed(1'b0, 32'd19999);
    feed(1'b1, 32'd19998);
    feed(1'b1, 32'd19000);
    // press across the timestamp wrap
    feed(1'b0, 32'hFFFF_FFF0);
    feed(1'b0, 32'h0000_0030);
    feed(1'b1, 32'h0000_0040);
    feed(1'b1, 32'h0000_0080);

    run_phase(16'd0, 16'd0, 16'd0, 150);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 150);
    run_phase(16'd0, 16'hFFFF, 16'd0, 100);
    repeat (4) run_phase(16'($urandom_range(0, 40)), 16'($urandom_range(0, 400)),
                         16'($urandom_range(0, 600)), 150);
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 100);
    quiet_tail = 1'b1;
    run_phase(16'($urandom_range(0, 20)), 16'($urandom_range(0, 200)),
              16'($urandom_range(0, 300)), 150);
    drain_results();
    repeat (8) @(posedge clk);

    $display("tb_top: %0d polls checked over %0d threshold settings",
             sb.n_checked, n_settings);
    $display("tb_top: events seen: %0d prompt, %0d shutdown, %0d short press",
             sb.event_tally[EV_PROMPT], sb.event_tally[EV_SHUTDOWN], sb.event_tally[EV_SHORT]);
    if (sb.n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/pkc_pkg.sv
sv/pkc_cfg.sv
sv/pkc_core.sv
sv/power_key_press_classifier.sv
sim/tb_top.sv
